// ===== sv/rbsi_pkg.sv =====
// shared types and constants for the ray versus box slab test
package rbsi_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 16;
    localparam int AXES          = 3;
    localparam int LANES         = 2 * AXES;
    localparam int CFG_IDX_BITS  = 4;

    // register indexes on the config port
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MIN_X          = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MIN_Y          = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MIN_Z          = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MAX_X          = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MAX_Y          = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_MAX_Z          = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_PARALLEL_THRESHOLD = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_HIT_THRESHOLD      = 4'd7;

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    localparam logic [WORD_BITS-2:0] PARALLEL_THRESHOLD_RESET = (WORD_BITS-1)'(1);
    localparam logic [WORD_BITS-2:0] HIT_THRESHOLD_RESET      = (WORD_BITS-1)'(7);

    typedef struct packed {
        word_t origin_x;
        word_t origin_y;
        word_t origin_z;
        word_t heading_x;
        word_t heading_y;
        word_t heading_z;
    } ray_t;

    typedef struct packed {
        logic [1:0] hit_count;
        word_t      first_distance;
        word_t      second_distance;
    } hit_t;

    typedef struct packed {
        word_t                box_min_x;
        word_t                box_min_y;
        word_t                box_min_z;
        word_t                box_max_x;
        word_t                box_max_y;
        word_t                box_max_z;
        logic [WORD_BITS-2:0] parallel_threshold;
        logic [WORD_BITS-2:0] hit_threshold;
    } box_cfg_t;

    // one restoring divider lane: remainder, quotient so far, numerator bits still to shift in
    typedef struct packed {
        logic [WORD_BITS-1:0] r;
        logic [WORD_BITS-1:0] q;
        logic [WORD_BITS-1:0] n;
        logic [WORD_BITS-1:0] dv;
        logic                 neg;
        logic                 ovf;
    } div_lane_t;

    // lanes 2a and 2a+1 hold the lower and upper slab of axis a
    typedef struct packed {
        div_lane_t [LANES-1:0] lane;
        logic [AXES-1:0]       par;
        logic                  miss;
    } div_word_t;

endpackage

// ===== sv/rbsi_prep.sv =====
// front stages: slab offsets, heading magnitude, parallel test, divider setup
module rbsi_prep (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rbsi_pkg::ray_t      in_data,
    input  rbsi_pkg::box_cfg_t  cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output rbsi_pkg::div_word_t out_data
);

    localparam int WB = rbsi_pkg::WORD_BITS;
    localparam int FB = rbsi_pkg::FRACTION_BITS;
    localparam int NA = rbsi_pkg::AXES;

    typedef struct packed {
        logic [WB:0]   diff_lo;
        logic [WB:0]   diff_hi;
        logic [WB-1:0] dmag;
        logic          dneg;
        logic          dzero;
        logic          outside;
    } axis_a_t;

    typedef struct packed {
        logic [WB-1:0] mlo;
        logic [WB-1:0] mhi;
        logic          nlo;
        logic          nhi;
        logic [WB-1:0] dmag;
        logic          par;
    } axis_b_t;

    typedef struct packed {
        axis_a_t [NA-1:0] ax;
    } stage_a_t;

    typedef struct packed {
        axis_b_t [NA-1:0] ax;
        logic             miss;
    } stage_b_t;

    function automatic rbsi_pkg::div_lane_t lane_init(
        logic [WB-1:0] m,
        logic [WB-1:0] dv,
        logic          neg
    );
        rbsi_pkg::div_lane_t l;
        logic [WB-1:0]       top;
        top   = {{FB{1'b0}}, m[WB-1:WB-FB]};
        l.r   = top;
        l.q   = '0;
        l.n   = {m[WB-FB-1:0], {FB{1'b0}}};
        l.dv  = dv;
        l.neg = neg;
        l.ovf = (top >= dv);
        return l;
    endfunction

    rbsi_pkg::word_t o_w  [NA];
    rbsi_pkg::word_t d_w  [NA];
    rbsi_pkg::word_t lo_w [NA];
    rbsi_pkg::word_t hi_w [NA];

    assign o_w[0]  = in_data.origin_x;
    assign o_w[1]  = in_data.origin_y;
    assign o_w[2]  = in_data.origin_z;
    assign d_w[0]  = in_data.heading_x;
    assign d_w[1]  = in_data.heading_y;
    assign d_w[2]  = in_data.heading_z;
    assign lo_w[0] = cfg.box_min_x;
    assign lo_w[1] = cfg.box_min_y;
    assign lo_w[2] = cfg.box_min_z;
    assign hi_w[0] = cfg.box_max_x;
    assign hi_w[1] = cfg.box_max_y;
    assign hi_w[2] = cfg.box_max_z;

    stage_a_t            a_reg, a_next;
    stage_b_t            b_reg, b_next;
    rbsi_pkg::div_word_t c_reg, c_next;
    logic                a_valid_reg, b_valid_reg, c_valid_reg;
    logic                adv_a, adv_b, adv_c;

    assign adv_c    = !c_valid_reg || out_ready;
    assign adv_b    = !b_valid_reg || adv_c;
    assign adv_a    = !a_valid_reg || adv_b;
    assign in_ready = adv_a;

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            a_next.ax[a].diff_lo = {lo_w[a][WB-1], lo_w[a]} - {o_w[a][WB-1], o_w[a]};
            a_next.ax[a].diff_hi = {hi_w[a][WB-1], hi_w[a]} - {o_w[a][WB-1], o_w[a]};
            a_next.ax[a].dmag    = d_w[a][WB-1] ? (~d_w[a] + 1'b1) : d_w[a];
            a_next.ax[a].dneg    = d_w[a][WB-1];
            a_next.ax[a].dzero   = (d_w[a] == '0);
            a_next.ax[a].outside = (o_w[a] < lo_w[a]) || (o_w[a] > hi_w[a]);
        end
    end

    always_comb begin
        b_next.miss = 1'b0;
        for (int a = 0; a < NA; a++) begin
            b_next.ax[a].mlo  = a_reg.ax[a].diff_lo[WB] ? (~a_reg.ax[a].diff_lo[WB-1:0] + 1'b1)
                                                        : a_reg.ax[a].diff_lo[WB-1:0];
            b_next.ax[a].mhi  = a_reg.ax[a].diff_hi[WB] ? (~a_reg.ax[a].diff_hi[WB-1:0] + 1'b1)
                                                        : a_reg.ax[a].diff_hi[WB-1:0];
            b_next.ax[a].nlo  = a_reg.ax[a].diff_lo[WB] ^ a_reg.ax[a].dneg;
            b_next.ax[a].nhi  = a_reg.ax[a].diff_hi[WB] ^ a_reg.ax[a].dneg;
            b_next.ax[a].dmag = a_reg.ax[a].dmag;
            b_next.ax[a].par  = a_reg.ax[a].dzero
                              || (a_reg.ax[a].dmag < {1'b0, cfg.parallel_threshold});
            b_next.miss       = b_next.miss || (b_next.ax[a].par && a_reg.ax[a].outside);
        end
    end

    always_comb begin
        c_next.miss = b_reg.miss;
        for (int a = 0; a < NA; a++) begin
            c_next.lane[2*a]   = lane_init(b_reg.ax[a].mlo, b_reg.ax[a].dmag, b_reg.ax[a].nlo);
            c_next.lane[2*a+1] = lane_init(b_reg.ax[a].mhi, b_reg.ax[a].dmag, b_reg.ax[a].nhi);
            c_next.par[a]      = b_reg.ax[a].par;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (adv_a) a_valid_reg <= in_valid;
            if (adv_b) b_valid_reg <= a_valid_reg;
            if (adv_c) c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_a) a_reg <= a_next;
        if (adv_b) b_reg <= b_next;
        if (adv_c) c_reg <= c_next;
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_reg;

endmodule

// ===== sv/rbsi_div.sv =====
// pipelined restoring divider, one quotient bit per stage for all six slabs
module rbsi_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rbsi_pkg::div_word_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rbsi_pkg::div_word_t out_data
);

    localparam int WB = rbsi_pkg::WORD_BITS;

    function automatic rbsi_pkg::div_lane_t div_step(rbsi_pkg::div_lane_t l);
        rbsi_pkg::div_lane_t s;
        logic [WB-1:0]       rs;
        logic [WB:0]         diff;
        s    = l;
        rs   = {l.r[WB-2:0], l.n[WB-1]};
        diff = {1'b0, rs} - {1'b0, l.dv};
        if (!diff[WB]) begin
            s.r = diff[WB-1:0];
            s.q = {l.q[WB-2:0], 1'b1};
        end else begin
            s.r = rs;
            s.q = {l.q[WB-2:0], 1'b0};
        end
        s.n = {l.n[WB-2:0], 1'b0};
        return s;
    endfunction

    rbsi_pkg::div_word_t stage_reg [WB];
    rbsi_pkg::div_word_t stage_next [WB];
    rbsi_pkg::div_word_t src_data [WB];
    logic [WB-1:0]       valid_reg;
    logic [WB-1:0]       src_valid;
    logic [WB:0]         adv;

    assign adv[WB]   = out_ready;
    assign src_valid = {valid_reg[WB-2:0], in_valid};
    assign src_data[0] = in_data;

    for (genvar k = 0; k < WB; k++) begin : g_stage
        if (k > 0) begin : g_link
            assign src_data[k] = stage_reg[k-1];
        end

        assign adv[k] = !valid_reg[k] || adv[k+1];

        always_comb begin
            stage_next[k] = src_data[k];
            for (int j = 0; j < rbsi_pkg::LANES; j++) begin
                stage_next[k].lane[j] = div_step(src_data[k].lane[j]);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                valid_reg[k] <= src_valid[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[k]) stage_reg[k] <= stage_next[k];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[WB-1];
    assign out_data  = stage_reg[WB-1];

endmodule

// ===== sv/rbsi_resolve.sv =====
// back stages: quotient saturation, slab ordering, interval narrowing, hit report
module rbsi_resolve (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rbsi_pkg::div_word_t in_data,
    input  rbsi_pkg::box_cfg_t  cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output rbsi_pkg::hit_t      out_data
);

    localparam int WB = rbsi_pkg::WORD_BITS;
    localparam int NA = rbsi_pkg::AXES;
    localparam int NL = rbsi_pkg::LANES;

    typedef struct packed {
        rbsi_pkg::word_t [NL-1:0] t;
        logic [NA-1:0]            par;
        logic                     miss;
    } r1_t;

    typedef struct packed {
        rbsi_pkg::word_t [NA-1:0] nr;
        rbsi_pkg::word_t [NA-1:0] fr;
        logic                     miss;
    } r2_t;

    typedef struct packed {
        rbsi_pkg::word_t na;
        rbsi_pkg::word_t nb;
        rbsi_pkg::word_t fa;
        rbsi_pkg::word_t fb;
        logic            miss;
    } r3_t;

    typedef struct packed {
        rbsi_pkg::word_t t_near;
        rbsi_pkg::word_t t_far;
        logic            miss;
    } r4_t;

    // signed, saturated quotient from magnitude, sign and overflow flag
    function automatic rbsi_pkg::word_t finish(rbsi_pkg::div_lane_t l);
        if (!l.neg) begin
            if (l.ovf || l.q[WB-1]) return rbsi_pkg::WORD_MAX;
            return $signed(l.q);
        end
        if (l.ovf || (l.q[WB-1] && (|l.q[WB-2:0]))) return rbsi_pkg::WORD_MIN;
        return $signed(~l.q + 1'b1);
    endfunction

    r1_t            r1_reg, r1_next;
    r2_t            r2_reg, r2_next;
    r3_t            r3_reg, r3_next;
    r4_t            r4_reg, r4_next;
    rbsi_pkg::hit_t r5_reg, r5_next;
    logic [4:0]     valid_reg;
    logic [4:0]     adv;

    assign adv[4]   = !valid_reg[4] || out_ready;
    assign adv[3]   = !valid_reg[3] || adv[4];
    assign adv[2]   = !valid_reg[2] || adv[3];
    assign adv[1]   = !valid_reg[1] || adv[2];
    assign adv[0]   = !valid_reg[0] || adv[1];
    assign in_ready = adv[0];

    always_comb begin
        r1_next.par  = in_data.par;
        r1_next.miss = in_data.miss;
        for (int j = 0; j < NL; j++) begin
            r1_next.t[j] = finish(in_data.lane[j]);
        end
    end

    // order each slab pair; a parallel axis leaves the interval alone
    always_comb begin
        r2_next.miss = r1_reg.miss;
        for (int a = 0; a < NA; a++) begin
            if (r1_reg.par[a]) begin
                r2_next.nr[a] = '0;
                r2_next.fr[a] = rbsi_pkg::WORD_MAX;
            end else if ($signed(r1_reg.t[2*a]) > $signed(r1_reg.t[2*a+1])) begin
                r2_next.nr[a] = r1_reg.t[2*a+1];
                r2_next.fr[a] = r1_reg.t[2*a];
            end else begin
                r2_next.nr[a] = r1_reg.t[2*a];
                r2_next.fr[a] = r1_reg.t[2*a+1];
            end
        end
    end

    always_comb begin
        r3_next.miss = r2_reg.miss;
        r3_next.na = ($signed(r2_reg.nr[0]) > $signed(r2_reg.nr[1])) ? r2_reg.nr[0]
                                                                      : r2_reg.nr[1];
        r3_next.nb = ($signed(r2_reg.nr[2]) > 0) ? r2_reg.nr[2] : '0;
        r3_next.fa = ($signed(r2_reg.fr[0]) < $signed(r2_reg.fr[1])) ? r2_reg.fr[0]
                                                                      : r2_reg.fr[1];
        r3_next.fb = r2_reg.fr[2];
    end

    always_comb begin
        r4_next.miss   = r3_reg.miss;
        r4_next.t_near = ($signed(r3_reg.na) > $signed(r3_reg.nb)) ? r3_reg.na : r3_reg.nb;
        r4_next.t_far  = ($signed(r3_reg.fa) < $signed(r3_reg.fb)) ? r3_reg.fa : r3_reg.fb;
    end

    rbsi_pkg::word_t thr;
    logic            miss_all, hit_near, hit_far;

    assign thr      = $signed({1'b0, cfg.hit_threshold});
    assign miss_all = r4_reg.miss || ($signed(r4_reg.t_near) > $signed(r4_reg.t_far))
                    || r4_reg.t_far[WB-1];
    assign hit_near = $signed(r4_reg.t_near) > $signed(thr);
    assign hit_far  = ($signed(r4_reg.t_far) > $signed(thr)) && (r4_reg.t_far != r4_reg.t_near);

    always_comb begin
        r5_next = '0;
        if (!miss_all) begin
            r5_next.hit_count = {1'b0, hit_near} + {1'b0, hit_far};
            if (hit_near) begin
                r5_next.first_distance = r4_reg.t_near;
                if (hit_far) r5_next.second_distance = r4_reg.t_far;
            end else if (hit_far) begin
                r5_next.first_distance = r4_reg.t_far;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) valid_reg[0] <= in_valid;
            if (adv[1]) valid_reg[1] <= valid_reg[0];
            if (adv[2]) valid_reg[2] <= valid_reg[1];
            if (adv[3]) valid_reg[3] <= valid_reg[2];
            if (adv[4]) valid_reg[4] <= valid_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) r1_reg <= r1_next;
        if (adv[1]) r2_reg <= r2_next;
        if (adv[2]) r3_reg <= r3_next;
        if (adv[3]) r4_reg <= r4_next;
        if (adv[4]) r5_reg <= r5_next;
    end

    assign out_valid = valid_reg[4];
    assign out_data  = r5_reg;

endmodule

// ===== sv/ray_box_slab_intersect.sv =====
// top level: ray against axis-aligned box, slab method, signed Q16.16
//
//   channel  direction  payload                                   transfer when
//   s_       in         ray_t (origin xyz, heading xyz)          s_valid && s_ready
//   m_       out        hit_t (hit_count, first/second distance) m_valid && m_ready
//   cfg_     in         cfg_index, cfg_data (box, thresholds)    cfg_valid && cfg_ready
//
// one ray per cycle while m_ready stays high; 3 setup stages, 32 divider
// stages (one quotient bit each, six slab divisions side by side), 5 finish stages
// every stage has its own valid bit and loads when it is empty or its successor
// moves, so a stall on m_ready fills bubbles before s_ready drops
// reset (aresetn low, synchronous) clears all valid bits and loads register defaults
// cfg_ready is always high; an index above the register list is dropped
module ray_box_slab_intersect (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // ray input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  rbsi_pkg::ray_t                       s_data,
    // hit result
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output rbsi_pkg::hit_t                       m_data,
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rbsi_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [rbsi_pkg::WORD_BITS-1:0]       cfg_data
);

    localparam int WB = rbsi_pkg::WORD_BITS;

    // box corners clear, thresholds at their defaults
    localparam rbsi_pkg::box_cfg_t CFG_RESET = {{(6*WB){1'b0}},
                                                rbsi_pkg::PARALLEL_THRESHOLD_RESET,
                                                rbsi_pkg::HIT_THRESHOLD_RESET};

    rbsi_pkg::box_cfg_t  cfg_reg, cfg_next;
    rbsi_pkg::div_word_t prep_data, div_data;
    logic                prep_valid, prep_ready;
    logic                div_valid, div_ready;

    // config writes are registered into cfg_reg, no back-pressure
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                rbsi_pkg::REG_BOX_MIN_X:          cfg_next.box_min_x = cfg_data;
                rbsi_pkg::REG_BOX_MIN_Y:          cfg_next.box_min_y = cfg_data;
                rbsi_pkg::REG_BOX_MIN_Z:          cfg_next.box_min_z = cfg_data;
                rbsi_pkg::REG_BOX_MAX_X:          cfg_next.box_max_x = cfg_data;
                rbsi_pkg::REG_BOX_MAX_Y:          cfg_next.box_max_y = cfg_data;
                rbsi_pkg::REG_BOX_MAX_Z:          cfg_next.box_max_z = cfg_data;
                rbsi_pkg::REG_PARALLEL_THRESHOLD: cfg_next.parallel_threshold = cfg_data[WB-2:0];
                rbsi_pkg::REG_HIT_THRESHOLD:      cfg_next.hit_threshold = cfg_data[WB-2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // slab offsets, heading magnitude, parallel check, divider seeds
    rbsi_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .cfg       (cfg_reg),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    // six divisions ((bound - origin) << 16) / heading, one bit per stage
    rbsi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    // saturate, order, narrow the interval, apply the hit threshold
    rbsi_resolve u_resolve (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   (div_data),
        .cfg       (cfg_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule
